@@ rtl/core/tcce_pkg.sv @@
// Shared types, codes and constants of the text console cursor engine.
// Used by every module under rtl/core; depends on nothing else.
package tcce_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    // Fixed field widths
    localparam int KIND_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int ADDR_FIELD_W = 11;
    localparam int POS_W        = 11;
    localparam int CELL_W       = 16;
    localparam int CFG_INDEX_W  = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

    localparam int TAB_STEP = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_ATTR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_ATTR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_ATTR  = 2'd2;

    // Attribute reset values
    localparam logic [ATTR_W-1:0] CHAR_ATTR_RESET   = 8'd10;
    localparam logic [ATTR_W-1:0] SCROLL_ATTR_RESET = 8'd10;
    localparam logic [ATTR_W-1:0] CLEAR_ATTR_RESET  = 8'd15;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [CHAR_W-1:0]       char_code;
        logic [ADDR_FIELD_W-1:0] cell_address;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_data;
    } out_item_t;

    typedef struct packed {
        logic [ATTR_W-1:0] char_attr;
        logic [ATTR_W-1:0] scroll_attr;
        logic [ATTR_W-1:0] clear_attr;
    } attr_cfg_t;

    // Classified operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_PRINT,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [CHAR_W-1:0]       code;
        logic [ADDR_FIELD_W-1:0] cell_address;
    } cmd_t;

endpackage

@@ rtl/core/tcce_front.sv @@
// Front end: request handshake and classification of requests into commands.
// Depends on tcce_pkg.
module tcce_front #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
    input  tcce_pkg::in_item_t in_item,
    input  logic               push,
    output logic               full,
    input  logic               queue_full,
    input  logic               init_busy,
    output tcce_pkg::cmd_t     cmd,
    output logic               cmd_push
);

    localparam int CellCount = COLUMNS * ROWS;
    localparam int CountW    = $clog2(CellCount + 1);
    localparam int CmpW      = (CountW > tcce_pkg::ADDR_FIELD_W) ? CountW
                                                                 : tcce_pkg::ADDR_FIELD_W;

    logic addr_ok;

    // Hold requests off while the queue is full or the store is cleared after reset
    assign full     = queue_full | init_busy;
    assign cmd_push = push & ~full;

    assign addr_ok = CmpW'(in_item.cell_address) < CmpW'(CellCount);

    // Classify; ignored codes, unused kinds and out-of-range reads become no-ops
    always_comb
    begin
        cmd.code         = in_item.char_code;
        cmd.cell_address = in_item.cell_address;
        cmd.op           = tcce_pkg::OP_NOP;
        case (in_item.kind)
            tcce_pkg::KIND_PUT:
            begin
                if (in_item.char_code == tcce_pkg::CHAR_BS)
                    cmd.op = tcce_pkg::OP_BS;
                else if (in_item.char_code == tcce_pkg::CHAR_TAB)
                    cmd.op = tcce_pkg::OP_TAB;
                else if (in_item.char_code == tcce_pkg::CHAR_CR)
                    cmd.op = tcce_pkg::OP_CR;
                else if (in_item.char_code == tcce_pkg::CHAR_LF)
                    cmd.op = tcce_pkg::OP_LF;
                else if (in_item.char_code inside
                         {[tcce_pkg::CHAR_SPACE:tcce_pkg::CHAR_LAST]})
                    cmd.op = tcce_pkg::OP_PRINT;
            end
            tcce_pkg::KIND_CLEAR:
                cmd.op = tcce_pkg::OP_CLEAR;
            tcce_pkg::KIND_READ:
            begin
                if (addr_ok)
                    cmd.op = tcce_pkg::OP_READ;
            end
            default:
                cmd.op = tcce_pkg::OP_NOP;
        endcase
    end

endmodule

@@ rtl/core/tcce_queue.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on tcce_pkg.
module tcce_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tcce_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output tcce_pkg::cmd_t rd_data,
    output logic           valid
);

    localparam int Depth = tcce_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    tcce_pkg::cmd_t      slots [Depth];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic                do_wr;
    logic                do_rd;

    assign full    = count_reg == CntW'(Depth);
    assign valid   = count_reg != '0;
    assign rd_data = slots[rd_ptr_reg];
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0
                                                              : wr_ptr_reg + PtrW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0
                                                              : rd_ptr_reg + PtrW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CntW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CntW'(1);
        end
    end

endmodule

@@ rtl/core/tcce_back.sv @@
// Back end: cursor state, cell store, scroll and clear sweeps, result register.
// Depends on tcce_pkg.
module tcce_back #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcce_pkg::attr_cfg_t attr,
    input  tcce_pkg::cmd_t      cmd,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    output logic                init_busy,
    output tcce_pkg::out_item_t out_item,
    output logic                empty,
    input  logic                pop
);

    localparam int CellCount = COLUMNS * ROWS;
    localparam int AddrW     = $clog2(CellCount);
    localparam int ColW      = $clog2(COLUMNS);
    localparam int RowW      = $clog2(ROWS);
    localparam int PosW      = (AddrW > tcce_pkg::POS_W) ? AddrW : tcce_pkg::POS_W;
    localparam int InW       = (AddrW > tcce_pkg::ADDR_FIELD_W) ? AddrW
                                                                : tcce_pkg::ADDR_FIELD_W;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_SWEEP,
        S_REPORT
    } state_t;

    // Cell store
    logic [tcce_pkg::CELL_W-1:0] mem [CellCount];
    logic [tcce_pkg::CELL_W-1:0] rd_data_reg;

    state_t                      state_reg;
    logic [ColW-1:0]             col_reg;
    logic [RowW-1:0]             row_reg;
    logic [AddrW-1:0]            row_base_reg;
    logic [AddrW-1:0]            top_base_reg;
    logic [AddrW-1:0]            sweep_addr_reg;
    logic [AddrW-1:0]            sweep_last_reg;
    logic [tcce_pkg::CELL_W-1:0] sweep_data_reg;
    logic                        is_read_reg;
    tcce_pkg::out_item_t         res_reg;
    logic                        res_valid_reg;

    logic                        take;
    logic [ColW:0]               col_ext;
    logic [ColW:0]               col_new;
    logic                        lf;
    logic                        wrap;
    logic                        row_step;
    logic                        do_scroll;
    logic [AddrW:0]              cur_sum;
    logic [AddrW-1:0]            cur_phys;
    logic [InW-1:0]              addr_wide;
    logic [AddrW:0]              rd_sum;
    logic [AddrW-1:0]            rd_phys;
    logic [AddrW:0]              top_sum;
    logic [AddrW-1:0]            top_next;
    logic [PosW-1:0]             pos_wide;
    logic                        mem_we;
    logic [AddrW-1:0]            mem_waddr;
    logic [tcce_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;

    assign take      = (state_reg == S_IDLE) && cmd_valid && !res_valid_reg;
    assign cmd_pop   = take;
    assign init_busy = state_reg == S_INIT;
    assign empty     = ~res_valid_reg;
    assign out_item  = res_reg;

    // Cursor column step for put commands
    always_comb
    begin
        col_ext = {1'b0, col_reg};
        lf      = 1'b0;
        case (cmd.op)
            tcce_pkg::OP_BS:
                col_new = (col_reg != '0) ? col_ext - (ColW+1)'(1) : col_ext;
            tcce_pkg::OP_TAB:
                col_new = (col_ext + (ColW+1)'(tcce_pkg::TAB_STEP))
                          & ~(ColW+1)'(tcce_pkg::TAB_STEP - 1);
            tcce_pkg::OP_CR:
                col_new = '0;
            tcce_pkg::OP_LF:
            begin
                col_new = '0;
                lf      = 1'b1;
            end
            tcce_pkg::OP_PRINT:
                col_new = col_ext + (ColW+1)'(1);
            default:
                col_new = col_ext;
        endcase
    end

    assign wrap      = col_new >= (ColW+1)'(COLUMNS);
    assign row_step  = lf | wrap;
    assign do_scroll = row_step && (row_reg == RowW'(ROWS - 1));

    // Physical cell under the cursor: ring offset plus logical index
    assign cur_sum  = (AddrW+1)'(top_base_reg) + (AddrW+1)'(row_base_reg)
                    + (AddrW+1)'(col_reg);
    assign cur_phys = (cur_sum >= (AddrW+1)'(CellCount))
                    ? AddrW'(cur_sum - (AddrW+1)'(CellCount)) : cur_sum[AddrW-1:0];

    // Physical cell of a read
    assign addr_wide = InW'(cmd.cell_address);
    assign rd_sum    = (AddrW+1)'(addr_wide[AddrW-1:0]) + (AddrW+1)'(top_base_reg);
    assign rd_phys   = (rd_sum >= (AddrW+1)'(CellCount))
                     ? AddrW'(rd_sum - (AddrW+1)'(CellCount)) : rd_sum[AddrW-1:0];

    // Ring offset after a scroll
    assign top_sum  = (AddrW+1)'(top_base_reg) + (AddrW+1)'(COLUMNS);
    assign top_next = (top_sum == (AddrW+1)'(CellCount)) ? '0 : top_sum[AddrW-1:0];

    assign pos_wide = PosW'(row_base_reg) + PosW'(col_reg);

    // Store write/read port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_phys;
        mem_wdata = {attr.char_attr, cmd.code};
        case (state_reg)
            S_INIT, S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = sweep_data_reg;
            end
            S_IDLE:
                mem_we = take && (cmd.op == tcce_pkg::OP_PRINT);
            default:
                mem_we = 1'b0;
        endcase
    end

    assign mem_re = take && (cmd.op == tcce_pkg::OP_READ);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[rd_phys];
    end

    // Command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            row_base_reg   <= '0;
            top_base_reg   <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= AddrW'(CellCount - 1);
            sweep_data_reg <= {tcce_pkg::CLEAR_ATTR_RESET, tcce_pkg::CHAR_SPACE};
            is_read_reg    <= 1'b0;
            res_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop && res_valid_reg)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    sweep_addr_reg <= sweep_addr_reg + AddrW'(1);
                    if (sweep_addr_reg == sweep_last_reg)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (take)
                    begin
                        is_read_reg <= cmd.op == tcce_pkg::OP_READ;
                        if (cmd.op == tcce_pkg::OP_CLEAR)
                        begin
                            col_reg        <= '0;
                            row_reg        <= '0;
                            row_base_reg   <= '0;
                            top_base_reg   <= '0;
                            sweep_addr_reg <= '0;
                            sweep_last_reg <= AddrW'(CellCount - 1);
                            sweep_data_reg <= {attr.clear_attr, tcce_pkg::CHAR_SPACE};
                            state_reg      <= S_SWEEP;
                        end
                        else
                        begin
                            col_reg <= wrap ? '0 : col_new[ColW-1:0];
                            if (do_scroll)
                            begin
                                // New bottom line is the old top row
                                sweep_addr_reg <= top_base_reg;
                                sweep_last_reg <= top_base_reg + AddrW'(COLUMNS - 1);
                                sweep_data_reg <= {attr.scroll_attr, tcce_pkg::CHAR_SPACE};
                                top_base_reg   <= top_next;
                                state_reg      <= S_SWEEP;
                            end
                            else
                            begin
                                if (row_step)
                                begin
                                    row_reg      <= row_reg + RowW'(1);
                                    row_base_reg <= row_base_reg + AddrW'(COLUMNS);
                                end
                                state_reg <= S_REPORT;
                            end
                        end
                    end
                end
                S_SWEEP:
                begin
                    sweep_addr_reg <= sweep_addr_reg + AddrW'(1);
                    if (sweep_addr_reg == sweep_last_reg)
                        state_reg <= S_REPORT;
                end
                S_REPORT:
                begin
                    res_reg.cursor_position <= pos_wide[tcce_pkg::POS_W-1:0];
                    res_reg.cell_data       <= is_read_reg ? rd_data_reg : '0;
                    res_valid_reg           <= 1'b1;
                    state_reg               <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/text_console_cursor_engine_core.sv @@
// Top level of the text console cursor engine: configuration registers and
// the front end, command queue and back end. Depends on tcce_pkg, tcce_front,
// tcce_queue and tcce_back.
//
// Usage:
//   Requests enter through push/full and in_item (put character, clear,
//   read one cell). Each request gives exactly one result on out_item,
//   taken with empty/pop: the cursor position after the request and, for a
//   read, the cell (attribute high byte, character low byte), else 0.
//   Attribute registers are written through cfg_write/cfg_index/cfg_data.
// Timing:
//   A two-entry command queue sits between front and back; the back end
//   takes one command at a time, in S_IDLE with no result waiting. For put,
//   read and no-op requests S_REPORT then registers the result on out_item.
//   A scroll first sweeps the COLUMNS cells of one row (80) and a clear all
//   COLUMNS*ROWS cells (2000) in S_SWEEP, one cell written per cycle
//   through the single store write port.
// Reset: the store is swept to blanks with attribute 15, one cell a cycle
//   over all COLUMNS*ROWS cells (2000); full stays high meanwhile.
// Stalls: while a result waits, the queue keeps accepting requests until full.
module text_console_cursor_engine_core #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcce_pkg::ROWS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  tcce_pkg::in_item_t                 in_item,
    output logic                               empty,
    input  logic                               pop,
    output tcce_pkg::out_item_t                out_item,
    input  logic                               cfg_write,
    input  logic [tcce_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcce_pkg::ATTR_W-1:0]        cfg_data
);

    tcce_pkg::attr_cfg_t attr_reg;
    tcce_pkg::cmd_t      front_cmd;
    tcce_pkg::cmd_t      back_cmd;
    logic                cmd_push;
    logic                cmd_pop;
    logic                cmd_valid;
    logic                queue_full;
    logic                init_busy;

    // Attribute registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg.char_attr   <= tcce_pkg::CHAR_ATTR_RESET;
            attr_reg.scroll_attr <= tcce_pkg::SCROLL_ATTR_RESET;
            attr_reg.clear_attr  <= tcce_pkg::CLEAR_ATTR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tcce_pkg::CFG_CHAR_ATTR:   attr_reg.char_attr   <= cfg_data;
                tcce_pkg::CFG_SCROLL_ATTR: attr_reg.scroll_attr <= cfg_data;
                tcce_pkg::CFG_CLEAR_ATTR:  attr_reg.clear_attr  <= cfg_data;
                default:                   attr_reg <= attr_reg;
            endcase
        end
    end

    // Front end
    tcce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_item    (in_item),
        .push       (push),
        .full       (full),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .cmd        (front_cmd),
        .cmd_push   (cmd_push)
    );

    // Command queue
    tcce_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (front_cmd),
        .full    (queue_full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .valid   (cmd_valid)
    );

    // Back end
    tcce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .attr      (attr_reg),
        .cmd       (back_cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .init_busy (init_busy),
        .out_item  (out_item),
        .empty     (empty),
        .pop       (pop)
    );

`ifndef NO_ASSERTIONS
    // No command leaves the queue during the reset sweep
    a_no_cmd_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !cmd_pop)
        else $error("command taken during reset sweep");

    // The back end works on one command at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> !cmd_pop)
        else $error("back end took commands in consecutive cycles");

    // A command is taken only when the result slot is free
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> empty)
        else $error("command taken while a result is pending");

    // Requests are refused during the reset sweep
    a_full_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> (full && !cmd_push))
        else $error("request accepted during reset sweep");
`endif

endmodule
